### rtl/htpa_pkg.sv
package htpa_pkg;

    // Default for the packet buffer size handed down from the top level
    localparam int MAX_PACKET_BYTES_DFLT = 65536;

    // Field widths
    localparam int OPCODE_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int OFFSET_W  = 32;
    localparam int CFG_W     = 17;
    localparam int WIDX_W    = 16;
    localparam int LEN_W     = 17;
    localparam int STATE_W   = 3;

    // Stream packing
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    localparam logic [CFG_W-1:0] FRAME_LIMIT_RST = 17'd65536;

    // Token kinds
    localparam logic [OPCODE_W-1:0] OP_BYTE      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_OFFSET    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DIRECTIVE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TEXT      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_EOL       = 3'd4;

    // Line parser states
    localparam logic [STATE_W-1:0] ST_INIT   = 3'd0;
    localparam logic [STATE_W-1:0] ST_LINE   = 3'd1;
    localparam logic [STATE_W-1:0] ST_OFFSET = 3'd2;
    localparam logic [STATE_W-1:0] ST_BYTE   = 3'd3;
    localparam logic [STATE_W-1:0] ST_TEXT   = 3'd4;

    typedef struct packed {
        logic               write_valid;
        logic [WIDX_W-1:0]  write_index;
        logic [BYTE_W-1:0]  write_data;
        logic               truncate_valid;
        logic               packet_done;
        logic [LEN_W-1:0]   pkt_len;
        logic [STATE_W-1:0] parser_state;
    } t_result;

endpackage

### rtl/htpa_step.sv
module htpa_step
    import htpa_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DFLT,
    parameter int CNT_W            = $clog2(MAX_PACKET_BYTES)
) (
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [BYTE_W-1:0]   i_byte_value,
    input  logic [OFFSET_W-1:0] i_offset_value,
    input  logic [STATE_W-1:0]  i_state,
    input  logic [CNT_W-1:0]    i_cnt,
    input  logic [OFFSET_W-1:0] i_base,
    input  logic [CFG_W-1:0]    i_frame_limit,
    output logic [STATE_W-1:0]  o_state_n,
    output logic [CNT_W-1:0]    o_cnt_n,
    output logic [OFFSET_W-1:0] o_base_n,
    output t_result             o_result
);

    localparam int INC_W = CNT_W + 1;
    localparam int CMP_W = (INC_W > CFG_W) ? INC_W : CFG_W;

    logic [OFFSET_W-1:0] cnt_ext;
    logic [OFFSET_W-1:0] rel;
    logic [INC_W-1:0]    cnt_inc;
    logic                full;

    assign cnt_ext = OFFSET_W'(i_cnt);
    assign rel     = i_offset_value - i_base;
    assign cnt_inc = INC_W'(i_cnt) + INC_W'(1);
    // Limit is the register capped at the buffer size; zero acts like one
    assign full    = (CMP_W'(cnt_inc) >= CMP_W'(i_frame_limit))
                  || (cnt_inc >= INC_W'(MAX_PACKET_BYTES));

    always_comb begin
        o_state_n = i_state;
        o_cnt_n   = i_cnt;
        o_base_n  = i_base;
        o_result  = '0;
        case (i_state)
            ST_INIT, ST_LINE: begin
                if (i_opcode == OP_OFFSET) begin
                    if (i_offset_value == '0) begin
                        o_result.packet_done = (i_cnt != '0);
                        o_result.pkt_len     = (i_cnt != '0) ? LEN_W'(i_cnt) : '0;
                        o_base_n  = '0;
                        o_cnt_n   = '0;
                        o_state_n = ST_OFFSET;
                    end else if (i_state == ST_LINE) begin
                        if (rel == cnt_ext) begin
                            o_state_n = ST_OFFSET;
                        end else if (rel < cnt_ext) begin
                            // drop the tail past the repeated offset
                            o_cnt_n = rel[CNT_W-1:0];
                            o_result.truncate_valid = 1'b1;
                            o_result.pkt_len        = LEN_W'(rel[CNT_W-1:0]);
                            o_state_n = ST_OFFSET;
                        end else begin
                            o_result.packet_done = (i_cnt != '0);
                            o_result.pkt_len     = (i_cnt != '0) ? LEN_W'(i_cnt) : '0;
                            o_base_n  = i_base + cnt_ext;
                            o_cnt_n   = '0;
                            o_state_n = ST_INIT;
                        end
                    end
                end
            end
            ST_OFFSET, ST_BYTE: begin
                case (i_opcode)
                    OP_BYTE: begin
                        o_state_n = ST_BYTE;
                        o_result.write_valid = 1'b1;
                        o_result.write_index = WIDX_W'(i_cnt);
                        o_result.write_data  = i_byte_value;
                        if (full) begin
                            o_result.packet_done = 1'b1;
                            o_result.pkt_len     = LEN_W'(cnt_inc);
                            o_base_n = i_base + OFFSET_W'(cnt_inc);
                            o_cnt_n  = '0;
                        end else begin
                            o_cnt_n = cnt_inc[CNT_W-1:0];
                        end
                    end
                    OP_OFFSET, OP_DIRECTIVE, OP_TEXT: o_state_n = ST_TEXT;
                    OP_EOL:                           o_state_n = ST_LINE;
                    default:                          o_state_n = i_state;
                endcase
            end
            default: begin
                if (i_opcode == OP_EOL) begin
                    o_state_n = ST_LINE;
                end
            end
        endcase
        o_result.parser_state = o_state_n;
    end

endmodule

### rtl/htpa_obuf.sv
module htpa_obuf
    import htpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_ready,
    input  logic    i_m_tready,
    output logic    o_m_tvalid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Accept a new result while empty or while the held one leaves this cycle
    assign o_ready = !r_valid || i_m_tready;
    assign n_valid = i_load || (r_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

endmodule

### rtl/hexdump_token_packet_assembler.sv
// The result of a token accepted at a clock edge is registered and is valid on m_axis
//   right after that edge.
// Throughput: one token per cycle unless stalled; the line state, byte count and packet base
//   register update in the accepting cycle, and the result register refills while it drains.
// Reset (synchronous, active low): parser to init, count and base to zero,
//   frame limit to 65536, result register empty.
module hexdump_token_packet_assembler
    import htpa_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DFLT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Token stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // byte_value[7:0], offset_value[39:8]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // opcode[2:0]
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // write_index[15:0], write_data[23:16],
                                                   // pkt_len[40:24],
                                                   // parser_state[43:41], zero[47:44]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // write_valid[0], truncate_valid[1],
                                                   // packet_done[2]
    // Frame length limit register
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES);

    // Parser state, bytes in the current packet, offset where that packet began
    logic [STATE_W-1:0]  r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [OFFSET_W-1:0] r_base;
    logic [CFG_W-1:0]    r_frame_limit;

    logic [STATE_W-1:0]  n_state;
    logic [CNT_W-1:0]    n_cnt;
    logic [OFFSET_W-1:0] n_base;
    t_result             step_res;
    t_result             out_res;
    logic                in_xact;

    // Config writes are to be made only while idle; the block does not enforce this and always takes them
    assign o_cfg_ready = 1'b1;

    assign in_xact = s_axis_tvalid && s_axis_tready;

    // Evaluate the accepted token against the current state
    htpa_step #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .CNT_W            (CNT_W)
    ) u_step (
        .i_opcode       (s_axis_tuser[OPCODE_W-1:0]),
        .i_byte_value   (s_axis_tdata[BYTE_W-1:0]),
        .i_offset_value (s_axis_tdata[BYTE_W+OFFSET_W-1:BYTE_W]),
        .i_state        (r_state),
        .i_cnt          (r_cnt),
        .i_base         (r_base),
        .i_frame_limit  (r_frame_limit),
        .o_state_n      (n_state),
        .o_cnt_n        (n_cnt),
        .o_base_n       (n_base),
        .o_result       (step_res)
    );

    // Advance the parser on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
            r_base  <= '0;
        end else if (in_xact) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_limit <= i_cfg_data;
        end
    end

    // Result register: hold the result until the downstream transaction completes
    htpa_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xact),
        .i_result   (step_res),
        .o_ready    (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_result   (out_res)
    );

    assign m_axis_tdata = {4'b0000, out_res.parser_state, out_res.pkt_len,
                           out_res.write_data, out_res.write_index};
    assign m_axis_tuser = {out_res.packet_done, out_res.truncate_valid,
                           out_res.write_valid};

endmodule

### rtl/htpa_chk.sv
module htpa_chk
    import htpa_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    logic [STATE_W-1:0] out_state;
    assign out_state = m_axis_tdata[43:41];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result stream valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_write_in_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> out_state == ST_BYTE && !m_axis_tuser[1])
        else $error("byte write outside byte state");

    a_trunc_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> out_state == ST_OFFSET && !m_axis_tuser[2])
        else $error("truncation outside offset state");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[40:24] != '0)
        else $error("completed packet with zero length");

endmodule

bind hexdump_token_packet_assembler htpa_chk u_htpa_chk (.*);
